[sv/wpd_pkg.sv]
// ----------------------------------------------------------------------------
// wpd_pkg
// Types, constants and sample conversion functions of the WAV PCM decoder.
// ----------------------------------------------------------------------------
package wpd_pkg;

  localparam logic [31:0] DATA_ID        = 32'h6461_7461;
  localparam logic [31:0] RIFF_HDR_LEN   = 32'd12;
  localparam logic [31:0] CHUNK_HDR_LEN  = 32'd8;
  localparam logic [31:0] FMT_BODY_LEN   = 32'd16;
  localparam logic [15:0] BITS_8         = 16'd8;
  localparam logic [15:0] BITS_16        = 16'd16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic [15:0]        channel_index;
    logic               frame_last;
    logic [31:0]        sample_rate;
  } out_item_t;

  typedef struct packed {
    logic        is16;
    logic [15:0] raw;
    logic [15:0] chan;
    logic        last;
    logic [31:0] rate;
  } work_t;

  // round(32768*(2b-255)/255) == 257*b + b[7] - 32768, top code saturates
  function automatic logic signed [15:0] conv8(input logic [7:0] b);
    logic [16:0] q;
    q = {1'b0, b, b} + {16'd0, b[7]};
    if (q[16]) begin
      return 16'sh7FFF;
    end
    return {~q[15], q[14:0]};
  endfunction

  // round(s*32768/32767) == s + (s >= 16384) - (s <= -16384), saturated
  function automatic logic signed [15:0] conv16(input logic [15:0] s);
    logic        up;
    logic        dn;
    logic [16:0] t;
    up = ~s[15] & s[14];
    dn = s[15] & (~s[14] | (s[13:0] == 14'd0));
    t  = {s[15], s} + {16'd0, up} - {16'd0, dn};
    if (t[16] != t[15]) begin
      return t[16] ? 16'sh8000 : 16'sh7FFF;
    end
    return t[15:0];
  endfunction

endpackage

[sv/wav_pcm_stream_decoder_core.sv]
// ----------------------------------------------------------------------------
// wav_pcm_stream_decoder_core
// WAV byte stream in, Q1.15 samples with channel index and rate out.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while not full, at most one sample per byte.
// Path: the edge taking a sample's last byte writes the work queue, and the
//   result register loads it from the queue while that register is empty or
//   being popped. Input stalls only while the work queue is full.
// rst_n (synchronous) clears parser, queue and result stage; file_start on a
//   byte restarts header parsing with that byte.
module wav_pcm_stream_decoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  wpd_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output wpd_pkg::out_item_t out_data
);
  import wpd_pkg::*;

  logic  acc;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  work_t q_wr_item;
  work_t q_rd_item;

  assign full = q_full;
  assign acc  = push && !q_full;

  wpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (acc),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_item   (q_wr_item)
  );

  wpd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty)
  );

  wpd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_item   (q_rd_item),
    .q_pop    (q_pop),
    .out_data (out_data),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

[sv/wpd_fifo.sv]
// ----------------------------------------------------------------------------
// wpd_fifo
// Short work queue between the header parser and the sample converter.
// ----------------------------------------------------------------------------
module wpd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wpd_pkg::work_t wr_item,
  output logic           full,
  input  logic           pop,
  output wpd_pkg::work_t rd_item,
  output logic           empty
);
  import wpd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  work_t          mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count lost a request");

  a_empty_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> rd_ptr_r == wr_ptr_r)
    else $error("queue pointers differ while empty");

endmodule

[sv/wpd_front.sv]
// ----------------------------------------------------------------------------
// wpd_front
// RIFF/fmt/chunk header parser; turns data bytes into sample requests.
// ----------------------------------------------------------------------------
module wpd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  wpd_pkg::in_item_t in_data,
  output logic              q_push,
  output wpd_pkg::work_t    q_item
);
  import wpd_pkg::*;

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_FMT_HDR,
    PH_FMT_BODY,
    PH_SKIP,
    PH_PAD,
    PH_CHUNK,
    PH_DATA
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] cnt_inc;
  logic [31:0] id_r, id_nxt;
  logic [31:0] len_r, len_nxt;
  logic [15:0] chans_r, chans_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [15:0] ch_cnt_r, ch_cnt_nxt;
  logic        last_hit;
  logic        emit;
  logic [7:0]  b;

  assign b = in_data.data_byte;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    chans_nxt  = chans_r;
    bits_nxt   = bits_r;
    rate_nxt   = rate_r;
    held_nxt   = held_r;
    ch_cnt_nxt = ch_cnt_r;
    emit       = 1'b0;
    q_item     = '0;

    if (in_valid && in_data.file_start) begin
      phase_nxt  = PH_RIFF;
      cnt_nxt    = '0;
      id_nxt     = '0;
      len_nxt    = '0;
      chans_nxt  = '0;
      bits_nxt   = '0;
      rate_nxt   = '0;
      held_nxt   = '0;
      ch_cnt_nxt = '0;
    end

    cnt_inc  = cnt_nxt + 32'd1;
    last_hit = ({1'b0, ch_cnt_nxt} + 17'd1) >= {1'b0, chans_nxt};

    if (in_valid) begin
      unique case (phase_nxt)
        PH_RIFF: begin
          if (cnt_inc >= RIFF_HDR_LEN) begin
            cnt_nxt   = '0;
            phase_nxt = PH_FMT_HDR;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        PH_FMT_HDR, PH_CHUNK: begin
          if (!cnt_nxt[2]) begin
            id_nxt = {id_nxt[23:0], b};
          end else begin
            unique case (cnt_nxt[1:0])
              2'd0: len_nxt        = {24'd0, b};
              2'd1: len_nxt[15:8]  = b;
              2'd2: len_nxt[23:16] = b;
              2'd3: len_nxt[31:24] = b;
            endcase
          end
          if (cnt_inc >= CHUNK_HDR_LEN) begin
            cnt_nxt = '0;
            if (phase_nxt == PH_FMT_HDR) begin
              phase_nxt = PH_FMT_BODY;
            end else if (id_nxt == DATA_ID) begin
              phase_nxt  = PH_DATA;
              ch_cnt_nxt = '0;
            end else if (len_nxt == '0) begin
              phase_nxt = PH_CHUNK;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        PH_FMT_BODY: begin
          unique case (cnt_nxt[3:0])
            4'd2:    chans_nxt        = {8'd0, b};
            4'd3:    chans_nxt[15:8]  = b;
            4'd4:    rate_nxt         = {24'd0, b};
            4'd5:    rate_nxt[15:8]   = b;
            4'd6:    rate_nxt[23:16]  = b;
            4'd7:    rate_nxt[31:24]  = b;
            4'd14:   bits_nxt         = {8'd0, b};
            4'd15:   bits_nxt[15:8]   = b;
            default: ;
          endcase
          cnt_nxt = cnt_inc;
          if (cnt_inc >= FMT_BODY_LEN) begin
            if (len_nxt > FMT_BODY_LEN) begin
              phase_nxt = PH_SKIP;
            end else begin
              cnt_nxt   = '0;
              phase_nxt = len_nxt[0] ? PH_PAD : PH_CHUNK;
            end
          end
        end
        PH_SKIP: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= len_nxt) begin
            cnt_nxt   = '0;
            phase_nxt = len_nxt[0] ? PH_PAD : PH_CHUNK;
          end
        end
        PH_PAD: begin
          cnt_nxt   = '0;
          phase_nxt = PH_CHUNK;
        end
        PH_DATA: begin
          if (chans_nxt != '0) begin
            if (bits_nxt == BITS_8) begin
              emit        = 1'b1;
              q_item.is16 = 1'b0;
              q_item.raw  = {8'd0, b};
            end else if (bits_nxt == BITS_16) begin
              if (!cnt_nxt[0]) begin
                held_nxt = b;
                cnt_nxt  = 32'd1;
              end else begin
                cnt_nxt     = '0;
                emit        = 1'b1;
                q_item.is16 = 1'b1;
                q_item.raw  = {b, held_nxt};
              end
            end
          end
          if (emit) begin
            q_item.chan = ch_cnt_nxt;
            q_item.last = last_hit;
            q_item.rate = rate_nxt;
            ch_cnt_nxt  = last_hit ? '0 : ch_cnt_nxt + 16'd1;
          end
        end
        default: ;
      endcase
    end
    q_push = emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_RIFF;
      cnt_r    <= '0;
      id_r     <= '0;
      len_r    <= '0;
      chans_r  <= '0;
      bits_r   <= '0;
      rate_r   <= '0;
      held_r   <= '0;
      ch_cnt_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      id_r     <= id_nxt;
      len_r    <= len_nxt;
      chans_r  <= chans_nxt;
      bits_r   <= bits_nxt;
      rate_r   <= rate_nxt;
      held_r   <= held_nxt;
      ch_cnt_r <= ch_cnt_nxt;
    end
  end

  a_push_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> in_valid && !in_data.file_start && phase_r == PH_DATA)
    else $error("sample request outside data phase");

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA && chans_r != '0) |-> ch_cnt_r < chans_r)
    else $error("channel counter out of range");

  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RIFF || phase_r == PH_FMT_HDR || phase_r == PH_CHUNK)
      |-> cnt_r < RIFF_HDR_LEN)
    else $error("header byte count overran");

  a_width_16: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_item.is16) |-> bits_r == BITS_16)
    else $error("16-bit request with other sample width");

endmodule

[sv/wpd_back.sv]
// ----------------------------------------------------------------------------
// wpd_back
// Sample converter to Q1.15 with a registered result stage.
// ----------------------------------------------------------------------------
module wpd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  wpd_pkg::work_t     q_item,
  output logic               q_pop,
  output wpd_pkg::out_item_t out_data,
  output logic               empty,
  input  logic               pop
);
  import wpd_pkg::*;

  logic      valid_r;
  out_item_t res_r, res_nxt;

  assign q_pop    = !q_empty && (!valid_r || pop);
  assign empty    = !valid_r;
  assign out_data = res_r;

  always_comb begin
    res_nxt.sample_value  = q_item.is16 ? conv16(q_item.raw) : conv8(q_item.raw[7:0]);
    res_nxt.channel_index = q_item.chan;
    res_nxt.frame_last    = q_item.last;
    res_nxt.sample_rate   = q_item.rate;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule
